@@ src/hstwm_pkg.sv @@
// shared types and constants for the two-wire humidity sensor measurement master
// no dependencies; used by every module of the block and by the port checker

package hstwm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_START  = 5'd1,
    PH_CMD    = 5'd2,
    PH_CACK   = 5'd3,
    PH_WAIT   = 5'd4,
    PH_SETTLE = 5'd5,
    PH_READ   = 5'd6,
    PH_RACK   = 5'd7,
    PH_RPRE   = 5'd8,
    PH_RHI    = 5'd9,
    PH_RLO    = 5'd10
  } phase_t;

  // request opcodes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_TEMP     = 2'd1;
  localparam logic [1:0] OP_HUMIDITY = 2'd2;

  // register indexes on the config port
  localparam logic REG_WAIT_LIMIT   = 1'b0;
  localparam logic REG_SETTLE_TICKS = 1'b1;

  localparam logic [15:0] WAIT_LIMIT_RST   = 16'd65535;
  localparam logic [15:0] SETTLE_TICKS_RST = 16'd500;

  // start frame, bit i is tick i
  localparam logic [7:0] START_CLK = 8'b0011_0110;
  localparam logic [7:0] START_DAT = 8'b0110_0011;

  localparam logic [7:0] CMD_TEMP     = 8'd3;
  localparam logic [7:0] CMD_HUMIDITY = 8'd5;

  // output tdata bit positions
  localparam int OUT_CLK_BIT     = 0;
  localparam int OUT_REL_BIT     = 1;
  localparam int OUT_BUSY_BIT    = 2;
  localparam int OUT_DONE_BIT    = 3;
  localparam int OUT_ACK_BIT     = 28;
  localparam int OUT_TIMEOUT_BIT = 29;

  typedef struct packed {
    logic [15:0] wait_limit;
    logic [15:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic        clock_level;
    logic        data_release;
    logic        busy_res;
    logic        done_res;
    logic [15:0] measured_value;
    logic [7:0]  checksum_byte;
    logic        ack_missing;
    logic        ready_timeout;
  } result_t;

endpackage

@@ src/hstwm_cfg.sv @@
// apb register file: wait_limit and settle_ticks
// depends on hstwm_pkg

module hstwm_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output hstwm_pkg::cfg_t   cfg
);

  logic [15:0] wait_limit;
  logic [15:0] settle_ticks;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_limit   <= hstwm_pkg::WAIT_LIMIT_RST;
      settle_ticks <= hstwm_pkg::SETTLE_TICKS_RST;
    end else if (wr_en) begin
      if (paddr[2] == hstwm_pkg::REG_WAIT_LIMIT) wait_limit <= pwdata[15:0];
      else settle_ticks <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == hstwm_pkg::REG_SETTLE_TICKS) prdata = {16'd0, settle_ticks};
    else prdata = {16'd0, wait_limit};
  end

  assign cfg.wait_limit   = wait_limit;
  assign cfg.settle_ticks = settle_ticks;

endmodule

@@ src/hstwm_fsm.sv @@
// sequence state machine, stepped once per accepted tick
// depends on hstwm_pkg

module hstwm_fsm #(
  parameter int RESET_PULSES = 9,
  parameter int WAIT_WIDTH   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [1:0]         opcode,
  input  logic               data_line,
  input  hstwm_pkg::cfg_t    cfg,
  output hstwm_pkg::result_t res
);

  localparam int CW = (WAIT_WIDTH > 16) ? WAIT_WIDTH : 16;
  localparam logic [CW-1:0] CNT_MAX = CW'((64'd1 << WAIT_WIDTH) - 64'd1);

  hstwm_pkg::phase_t     phase, phase_next;
  logic [3:0]            bit_counter, bit_counter_next;
  logic [1:0]            byte_counter, byte_counter_next;
  logic [7:0]            shift_register, shift_register_next;
  logic [15:0]           value_register, value_register_next;
  logic [7:0]            checksum_register, checksum_register_next;
  logic [WAIT_WIDTH-1:0] wait_counter, wait_counter_next;
  logic                  command_kind, command_kind_next;
  logic [1:0]            error_flags, error_flags_next;

  logic [CW-1:0]         wait_ext, settle_ext;
  logic [CW-1:0]         wait_cap_w, settle_cap_w;
  logic [WAIT_WIDTH-1:0] wait_cap, settle_cap;

  hstwm_pkg::phase_t     ph;
  logic [3:0]            bc;
  logic [7:0]            cmd;
  logic [2:0]            cmd_idx;
  logic [4:0]            pulse_cnt;
  logic                  ackd;
  logic                  clk_out, rel_out, done_out, busy_out;

  // limits capped at the counter range
  assign wait_ext     = CW'(cfg.wait_limit);
  assign settle_ext   = CW'(cfg.settle_ticks);
  assign wait_cap_w   = (wait_ext > CNT_MAX) ? CNT_MAX : wait_ext;
  assign settle_cap_w = (settle_ext > CNT_MAX) ? CNT_MAX : settle_ext;
  assign wait_cap     = wait_cap_w[WAIT_WIDTH-1:0];
  assign settle_cap   = settle_cap_w[WAIT_WIDTH-1:0];

  always_comb begin
    phase_next             = phase;
    bit_counter_next       = bit_counter;
    byte_counter_next      = byte_counter;
    shift_register_next    = shift_register;
    value_register_next    = value_register;
    checksum_register_next = checksum_register;
    wait_counter_next      = wait_counter;
    command_kind_next      = command_kind;
    error_flags_next       = error_flags;
    clk_out                = 1'b0;
    rel_out                = 1'b1;
    done_out               = 1'b0;
    ph                     = phase;
    bc                     = bit_counter;
    cmd                    = hstwm_pkg::CMD_TEMP;
    cmd_idx                = 3'd0;
    pulse_cnt              = 5'd0;
    ackd                   = 1'b0;

    // a request in idle starts the frame on this same tick
    if (phase == hstwm_pkg::PH_IDLE &&
        (opcode == hstwm_pkg::OP_TEMP || opcode == hstwm_pkg::OP_HUMIDITY)) begin
      command_kind_next = (opcode == hstwm_pkg::OP_HUMIDITY);
      error_flags_next  = 2'b00;
      ph                = hstwm_pkg::PH_START;
      bc                = 4'd0;
      phase_next        = hstwm_pkg::PH_START;
      bit_counter_next  = 4'd0;
    end
    busy_out = (ph != hstwm_pkg::PH_IDLE);

    case (ph)
      hstwm_pkg::PH_IDLE: begin
        phase_next = hstwm_pkg::PH_IDLE;
      end
      hstwm_pkg::PH_START: begin
        clk_out = hstwm_pkg::START_CLK[bc[2:0]];
        rel_out = hstwm_pkg::START_DAT[bc[2:0]];
        if (bc >= 4'd7) begin
          phase_next       = hstwm_pkg::PH_CMD;
          bit_counter_next = 4'd0;
        end else bit_counter_next = bc + 4'd1;
      end
      hstwm_pkg::PH_CMD: begin
        cmd     = command_kind_next ? hstwm_pkg::CMD_HUMIDITY : hstwm_pkg::CMD_TEMP;
        cmd_idx = 3'd7 - bc[3:1];
        rel_out = cmd[cmd_idx];
        clk_out = bc[0];
        if (bc == 4'd15) begin
          phase_next       = hstwm_pkg::PH_CACK;
          bit_counter_next = 4'd0;
        end else bit_counter_next = bc + 4'd1;
      end
      hstwm_pkg::PH_CACK: begin
        if (bc == 4'd0) begin
          bit_counter_next = 4'd1;
        end else begin
          clk_out = 1'b1;
          if (data_line) error_flags_next[0] = 1'b1;
          phase_next        = hstwm_pkg::PH_WAIT;
          wait_counter_next = '0;
          bit_counter_next  = 4'd0;
        end
      end
      hstwm_pkg::PH_WAIT: begin
        if (!data_line) begin
          phase_next        = hstwm_pkg::PH_SETTLE;
          wait_counter_next = '0;
        end else if (wait_counter >= wait_cap) begin
          error_flags_next[1] = 1'b1;
          phase_next          = hstwm_pkg::PH_SETTLE;
          wait_counter_next   = '0;
        end else wait_counter_next = wait_counter + 1'b1;
      end
      hstwm_pkg::PH_SETTLE: begin
        if (wait_counter >= settle_cap) begin
          phase_next          = hstwm_pkg::PH_READ;
          bit_counter_next    = 4'd0;
          byte_counter_next   = 2'd0;
          shift_register_next = 8'd0;
        end else wait_counter_next = wait_counter + 1'b1;
      end
      hstwm_pkg::PH_READ: begin
        if (!bc[0]) begin
          clk_out             = 1'b1;
          shift_register_next = {shift_register[6:0], data_line};
        end
        if (bc == 4'd15) begin
          phase_next       = hstwm_pkg::PH_RACK;
          bit_counter_next = 4'd0;
        end else bit_counter_next = bc + 4'd1;
      end
      hstwm_pkg::PH_RACK: begin
        ackd = (byte_counter >= 2'd2);
        if (bc == 4'd0) begin
          rel_out          = ackd;
          bit_counter_next = 4'd1;
        end else if (bc == 4'd1) begin
          rel_out          = ackd;
          clk_out          = 1'b1;
          bit_counter_next = 4'd2;
        end else begin
          bit_counter_next = 4'd0;
          if (byte_counter == 2'd0) begin
            value_register_next = {shift_register, 8'd0};
          end else if (byte_counter == 2'd1) begin
            value_register_next = {value_register[15:8], shift_register};
          end else begin
            checksum_register_next = shift_register;
            done_out               = 1'b1;
          end
          if (byte_counter >= 2'd2) begin
            phase_next = (error_flags_next != 2'b00) ? hstwm_pkg::PH_RPRE
                                                     : hstwm_pkg::PH_IDLE;
          end else begin
            byte_counter_next   = byte_counter + 2'd1;
            shift_register_next = 8'd0;
            phase_next          = hstwm_pkg::PH_READ;
          end
        end
      end
      hstwm_pkg::PH_RPRE: begin
        phase_next       = hstwm_pkg::PH_RHI;
        bit_counter_next = 4'd0;
      end
      hstwm_pkg::PH_RHI: begin
        clk_out    = 1'b1;
        phase_next = hstwm_pkg::PH_RLO;
      end
      hstwm_pkg::PH_RLO: begin
        pulse_cnt = {1'b0, bc} + 5'd1;
        if (pulse_cnt >= 5'(RESET_PULSES)) begin
          phase_next       = hstwm_pkg::PH_IDLE;
          bit_counter_next = 4'd0;
        end else begin
          bit_counter_next = bc + 4'd1;
          phase_next       = hstwm_pkg::PH_RHI;
        end
      end
      default: begin
        phase_next = hstwm_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= hstwm_pkg::PH_IDLE;
      bit_counter       <= 4'd0;
      byte_counter      <= 2'd0;
      shift_register    <= 8'd0;
      value_register    <= 16'd0;
      checksum_register <= 8'd0;
      wait_counter      <= '0;
      command_kind      <= 1'b0;
      error_flags       <= 2'b00;
    end else if (step) begin
      phase             <= phase_next;
      bit_counter       <= bit_counter_next;
      byte_counter      <= byte_counter_next;
      shift_register    <= shift_register_next;
      value_register    <= value_register_next;
      checksum_register <= checksum_register_next;
      wait_counter      <= wait_counter_next;
      command_kind      <= command_kind_next;
      error_flags       <= error_flags_next;
    end
  end

  assign res.clock_level    = clk_out;
  assign res.data_release   = rel_out;
  assign res.busy_res       = busy_out;
  assign res.done_res       = done_out;
  assign res.measured_value = value_register_next;
  assign res.checksum_byte  = checksum_register_next;
  assign res.ack_missing    = error_flags_next[0];
  assign res.ready_timeout  = error_flags_next[1];

endmodule

@@ src/humidity_sensor_two_wire_master_top.sv @@
// top level of the two-wire humidity sensor measurement master
// depends on hstwm_pkg, hstwm_cfg, hstwm_fsm
//
//   channel   | direction | carries
//   ----------+-----------+-----------------------------------------------
//   s_t*      | in        | one half-clock tick: opcode, sampled data line
//   m_t*      | out       | one result per tick: pin levels, status, value
//   apb       | in/out    | wait_limit (0x0), settle_ticks (0x4)
//
// a new item can be accepted in each cycle while the result register is empty or being drained
// the sequence state and the result register are updated in the cycle of acceptance
// the result register frees itself when taken, so s_tready stays high while m_tready is
// high; if a result waits, s_tready drops until it is taken
// synchronous reset returns the sequencer to idle and the registers to their reset values

module humidity_sensor_two_wire_master_top #(
  parameter int RESET_PULSES = 9,
  parameter int WAIT_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // tick stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] opcode, [2] data_line, [7:3] zero
  // result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] clock_level, [1] data_release, [2] busy_res,
                                 // [3] done_res, [19:4] measured_value,
                                 // [27:20] checksum_byte, [28] ack_missing,
                                 // [29] ready_timeout, [31:30] zero
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hstwm_pkg::cfg_t    cfg;
  hstwm_pkg::result_t res;
  logic               accept;

  // register file on the config port
  hstwm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // output register empty or being drained this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // sequencer advances by one tick per accepted item
  hstwm_fsm #(
    .RESET_PULSES (RESET_PULSES),
    .WAIT_WIDTH   (WAIT_WIDTH)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .opcode    (s_tdata[1:0]),
    .data_line (s_tdata[2]),
    .cfg       (cfg),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, res.ready_timeout, res.ack_missing, res.checksum_byte,
                  res.measured_value, res.done_res, res.busy_res,
                  res.data_release, res.clock_level};
    end
  end

endmodule

@@ src/hstwm_checker.sv @@
// port-level checker for the humidity sensor measurement master, bound to the top level
// depends on hstwm_pkg

module hstwm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // empty output stage always takes a tick
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  // a result only shows up after an accepted tick
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result item without an accepted tick");

  // completion only happens inside a running sequence, on a clock-low tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[hstwm_pkg::OUT_DONE_BIT] |->
      m_tdata[hstwm_pkg::OUT_BUSY_BIT] && !m_tdata[hstwm_pkg::OUT_CLK_BIT])
    else $error("done outside a measurement");

  // idle ticks leave the bus quiet
  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[hstwm_pkg::OUT_BUSY_BIT] |->
      !m_tdata[hstwm_pkg::OUT_CLK_BIT] && m_tdata[hstwm_pkg::OUT_REL_BIT])
    else $error("bus driven while idle");

endmodule

bind humidity_sensor_two_wire_master_top hstwm_checker u_hstwm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ dv/humidity_sensor_two_wire_master_top_tb.sv @@
// self-checking testbench for humidity_sensor_two_wire_master_top
// drives tick items and checks every result item against a tick-level predictor
// depends on hstwm_pkg and the rtl under src
`timescale 1ns / 1ps

module humidity_sensor_two_wire_master_top_tb;

  localparam int RESET_PULSES = 9;
  localparam int WAIT_WIDTH   = 16;

  // opcode 3 is not a request, the block must treat it like a plain tick
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // start frame levels, bit i belongs to tick i
  localparam logic [7:0] FRAME_CLK = 8'b0011_0110;
  localparam logic [7:0] FRAME_DAT = 8'b0110_0011;
  localparam logic [7:0] TEMP_COMMAND     = 8'd3;
  localparam logic [7:0] HUMIDITY_COMMAND = 8'd5;

  typedef enum int {READ_RANDOM, READ_ONES, READ_ZEROS} read_pattern_t;

  // internal sequencer state as seen from the pins
  typedef struct packed {
    hstwm_pkg::phase_t     phase;
    logic [3:0]            bit_cnt;
    logic [1:0]            byte_cnt;
    logic [7:0]            shreg;
    logic [15:0]           value;
    logic [7:0]            csum;
    logic [WAIT_WIDTH-1:0] wait_cnt;
    logic                  humidity;
    logic [1:0]            err;
  } seq_state_t;

  typedef struct packed {
    seq_state_t          nxt;
    hstwm_pkg::result_t  res;
  } tick_outcome_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       data_line;
  } tick_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [31:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  humidity_sensor_two_wire_master_top #(
    .RESET_PULSES(RESET_PULSES),
    .WAIT_WIDTH  (WAIT_WIDTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the two config registers, only changed while the block is idle
  logic [15:0] cfg_wait_limit = hstwm_pkg::WAIT_LIMIT_RST;
  logic [15:0] cfg_settle     = hstwm_pkg::SETTLE_TICKS_RST;

  tick_item_t         pending_ticks[$];     // items waiting to be driven
  hstwm_pkg::result_t expected_results[$];  // predicted result items, oldest first

  // the stimulus side runs its own copy of the sequencer so that it knows
  // which tick samples the ack, the ready wait and the read bits
  seq_state_t gen_st  = '0;
  seq_state_t pred_st = '0;

  bit bursts_on = 1'b1;
  int fail_count = 0;
  int queued_count = 0;
  int checked_count = 0;
  int done_count = 0;
  int flagged_done_count = 0;

  // one half-clock tick of the measurement sequencer
  function automatic tick_outcome_t sequencer_tick(input seq_state_t s, input logic [1:0] op,
                                                   input logic dl);
    tick_outcome_t o;
    hstwm_pkg::result_t r;
    logic [7:0] cmd;
    logic acked;
    r = '0;
    r.data_release = 1'b1;
    // a request only starts a sequence from idle
    if (s.phase == hstwm_pkg::PH_IDLE &&
        (op == hstwm_pkg::OP_TEMP || op == hstwm_pkg::OP_HUMIDITY)) begin
      s.humidity = (op == hstwm_pkg::OP_HUMIDITY);
      s.err      = 2'b00;
      s.phase    = hstwm_pkg::PH_START;
      s.bit_cnt  = '0;
    end
    r.busy_res = (s.phase != hstwm_pkg::PH_IDLE);
    case (s.phase)
      hstwm_pkg::PH_IDLE: ;
      hstwm_pkg::PH_START: begin
        r.clock_level  = FRAME_CLK[s.bit_cnt[2:0]];
        r.data_release = FRAME_DAT[s.bit_cnt[2:0]];
        if (s.bit_cnt >= 4'd7) begin
          s.phase   = hstwm_pkg::PH_CMD;
          s.bit_cnt = '0;
        end else begin
          s.bit_cnt = s.bit_cnt + 4'd1;
        end
      end
      hstwm_pkg::PH_CMD: begin
        // msb first, two ticks per bit, clock low then high
        cmd = s.humidity ? HUMIDITY_COMMAND : TEMP_COMMAND;
        r.data_release = cmd[3'd7 - s.bit_cnt[3:1]];
        r.clock_level  = s.bit_cnt[0];
        if (s.bit_cnt == 4'd15) begin
          s.phase   = hstwm_pkg::PH_CACK;
          s.bit_cnt = '0;
        end else begin
          s.bit_cnt = s.bit_cnt + 4'd1;
        end
      end
      hstwm_pkg::PH_CACK: begin
        if (s.bit_cnt == 4'd0) begin
          s.bit_cnt = 4'd1;
        end else begin
          r.clock_level = 1'b1;
          if (dl) s.err[0] = 1'b1;
          s.phase    = hstwm_pkg::PH_WAIT;
          s.wait_cnt = '0;
          s.bit_cnt  = '0;
        end
      end
      hstwm_pkg::PH_WAIT: begin
        if (!dl) begin
          s.phase    = hstwm_pkg::PH_SETTLE;
          s.wait_cnt = '0;
        end else if (s.wait_cnt >= cfg_wait_limit) begin
          s.err[1]   = 1'b1;
          s.phase    = hstwm_pkg::PH_SETTLE;
          s.wait_cnt = '0;
        end else begin
          s.wait_cnt = s.wait_cnt + 1'b1;
        end
      end
      hstwm_pkg::PH_SETTLE: begin
        if (s.wait_cnt >= cfg_settle) begin
          s.phase    = hstwm_pkg::PH_READ;
          s.bit_cnt  = '0;
          s.byte_cnt = '0;
          s.shreg    = '0;
        end else begin
          s.wait_cnt = s.wait_cnt + 1'b1;
        end
      end
      hstwm_pkg::PH_READ: begin
        // sample on the clock-high tick of each bit
        if (!s.bit_cnt[0]) begin
          r.clock_level = 1'b1;
          s.shreg = {s.shreg[6:0], dl};
        end
        if (s.bit_cnt == 4'd15) begin
          s.phase   = hstwm_pkg::PH_RACK;
          s.bit_cnt = '0;
        end else begin
          s.bit_cnt = s.bit_cnt + 4'd1;
        end
      end
      hstwm_pkg::PH_RACK: begin
        // the two value bytes are acked low, the checksum byte is not
        acked = (s.byte_cnt < 2'd2) ? 1'b0 : 1'b1;
        if (s.bit_cnt == 4'd0) begin
          r.data_release = acked;
          s.bit_cnt = 4'd1;
        end else if (s.bit_cnt == 4'd1) begin
          r.data_release = acked;
          r.clock_level  = 1'b1;
          s.bit_cnt = 4'd2;
        end else begin
          s.bit_cnt = '0;
          if (s.byte_cnt == 2'd0) begin
            s.value = {s.shreg, 8'h00};
          end else if (s.byte_cnt == 2'd1) begin
            s.value[7:0] = s.shreg;
          end else begin
            s.csum     = s.shreg;
            r.done_res = 1'b1;
          end
          if (s.byte_cnt < 2'd2) begin
            s.byte_cnt = s.byte_cnt + 2'd1;
            s.shreg    = '0;
            s.phase    = hstwm_pkg::PH_READ;
          end else begin
            s.phase = (s.err != 2'b00) ? hstwm_pkg::PH_RPRE : hstwm_pkg::PH_IDLE;
          end
        end
      end
      hstwm_pkg::PH_RPRE: begin
        s.phase   = hstwm_pkg::PH_RHI;
        s.bit_cnt = '0;
      end
      hstwm_pkg::PH_RHI: begin
        r.clock_level = 1'b1;
        s.phase = hstwm_pkg::PH_RLO;
      end
      hstwm_pkg::PH_RLO: begin
        if (int'(s.bit_cnt) + 1 >= RESET_PULSES) begin
          s.phase   = hstwm_pkg::PH_IDLE;
          s.bit_cnt = '0;
        end else begin
          s.bit_cnt = s.bit_cnt + 4'd1;
          s.phase   = hstwm_pkg::PH_RHI;
        end
      end
      default: s.phase = hstwm_pkg::PH_IDLE;
    endcase
    r.measured_value = s.value;
    r.checksum_byte  = s.csum;
    r.ack_missing    = s.err[0];
    r.ready_timeout  = s.err[1];
    o.nxt = s;
    o.res = r;
    return o;
  endfunction

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // tick driver: holds each item until taken, random gaps between items
  int send_gap = 0;
  tick_item_t next_tick;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      send_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        next_tick = pending_ticks.pop_front();
        s_tdata  <= {5'b0, next_tick.data_line, next_tick.opcode};
        s_tvalid <= 1'b1;
        if (bursts_on && $urandom_range(0, 6) == 0) send_gap = $urandom_range(1, 4);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure in short bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (bursts_on && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 4);
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // monitor: results are compared before this edge's input is predicted, since a
  // result can never belong to the item taken at the same edge
  hstwm_pkg::result_t want;
  tick_outcome_t seen_tick;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          check_field("clock_level", 16'(want.clock_level),
                      16'(m_tdata[hstwm_pkg::OUT_CLK_BIT]));
          check_field("data_release", 16'(want.data_release),
                      16'(m_tdata[hstwm_pkg::OUT_REL_BIT]));
          check_field("busy_res", 16'(want.busy_res),
                      16'(m_tdata[hstwm_pkg::OUT_BUSY_BIT]));
          check_field("done_res", 16'(want.done_res),
                      16'(m_tdata[hstwm_pkg::OUT_DONE_BIT]));
          check_field("measured_value", want.measured_value, m_tdata[19:4]);
          check_field("checksum_byte", 16'(want.checksum_byte), 16'(m_tdata[27:20]));
          check_field("ack_missing", 16'(want.ack_missing),
                      16'(m_tdata[hstwm_pkg::OUT_ACK_BIT]));
          check_field("ready_timeout", 16'(want.ready_timeout),
                      16'(m_tdata[hstwm_pkg::OUT_TIMEOUT_BIT]));
          if (want.done_res) begin
            done_count++;
            if (want.ack_missing || want.ready_timeout) flagged_done_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        seen_tick = sequencer_tick(pred_st, s_tdata[1:0], s_tdata[2]);
        pred_st = seen_tick.nxt;
        expected_results.push_back(seen_tick.res);
      end
    end
  end

  // queue one item and advance the stimulus-side sequencer copy
  task automatic send_tick(input logic [1:0] op, input logic dl);
    tick_outcome_t o;
    tick_item_t it;
    it.opcode    = op;
    it.data_line = dl;
    pending_ticks.push_back(it);
    o = sequencer_tick(gen_st, op, dl);
    gen_st = o.nxt;
    queued_count++;
  endtask

  // one full measurement from request to idle; the sensor side answers on the
  // sampled ticks, every other tick carries a random data level
  task automatic plan_measurement(input logic [1:0] req, input logic nack, input int high_ticks,
                                  input read_pattern_t pattern, input bit busy_noise);
    int highs_sent;
    logic dl;
    logic [1:0] op;
    highs_sent = 0;
    send_tick(req, 1'($urandom_range(0, 1)));
    while (gen_st.phase != hstwm_pkg::PH_IDLE) begin
      dl = 1'($urandom_range(0, 1));
      op = hstwm_pkg::OP_TICK;
      // requests while busy must be ignored
      if (busy_noise && $urandom_range(0, 7) == 0) op = 2'($urandom_range(0, 3));
      case (gen_st.phase)
        hstwm_pkg::PH_CACK: if (gen_st.bit_cnt == 4'd1) dl = nack;
        hstwm_pkg::PH_WAIT: begin
          dl = (highs_sent < high_ticks);
          highs_sent++;
        end
        hstwm_pkg::PH_READ: begin
          if (!gen_st.bit_cnt[0]) begin
            if (pattern == READ_ONES) dl = 1'b1;
            else if (pattern == READ_ZEROS) dl = 1'b0;
          end
        end
        default: ;
      endcase
      send_tick(op, dl);
    end
  endtask

  task automatic idle_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      send_tick(($urandom_range(0, 1) != 0) ? hstwm_pkg::OP_TICK : OP_UNUSED,
                1'($urandom_range(0, 1)));
    end
  endtask

  // every queued item gives one result, so all of them checked means idle
  task automatic wait_drained();
    @(posedge clk);
    while (checked_count != queued_count) @(posedge clk);
  endtask

  task automatic write_register(input logic reg_idx, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == hstwm_pkg::REG_WAIT_LIMIT) cfg_wait_limit = val;
    else cfg_settle = val;
  endtask

  task automatic configure(input logic [15:0] lim, input logic [15:0] settle);
    wait_drained();
    write_register(hstwm_pkg::REG_WAIT_LIMIT, lim);
    write_register(hstwm_pkg::REG_SETTLE_TICKS, settle);
  endtask

  // stimulus
  initial begin
    int random_start;
    int lim;
    int highs;
    bit broken;
    logic nack;
    @(negedge rst);

    // plain ticks with both opcodes that start nothing, both data levels
    send_tick(hstwm_pkg::OP_TICK, 1'b0);
    send_tick(hstwm_pkg::OP_TICK, 1'b1);
    send_tick(OP_UNUSED, 1'b0);
    send_tick(OP_UNUSED, 1'b1);

    // temperature at the reset wait limit with a short settle, ready after two ticks
    configure(hstwm_pkg::WAIT_LIMIT_RST, 16'd2);
    plan_measurement(hstwm_pkg::OP_TEMP, 1'b0, 2, READ_RANDOM, 1'b0);

    // zero limits: missing ack plus timeout, then the nine recovery pulses
    configure(16'd0, 16'd0);
    plan_measurement(hstwm_pkg::OP_HUMIDITY, 1'b1, 4, READ_ONES, 1'b1);
    // zero wait limit but the sensor is ready at once
    plan_measurement(hstwm_pkg::OP_TEMP, 1'b0, 0, READ_ZEROS, 1'b0);
    // missing ack alone
    plan_measurement(hstwm_pkg::OP_TEMP, 1'b1, 0, READ_RANDOM, 1'b0);

    // largest wait limit, short settle
    configure(16'd65535, 16'd3);
    plan_measurement(hstwm_pkg::OP_HUMIDITY, 1'b0, 3, READ_RANDOM, 1'b0);

    // random phases with mostly small limits, the last one without gaps or back-pressure
    random_start = queued_count;
    for (int p = 0; p < 6; p++) begin
      lim = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
      configure(lim[15:0], 16'($urandom_range(0, 6)));
      if (p == 5) begin
        wait_drained();
        bursts_on = 1'b0;
      end
      while (queued_count < random_start + 75 * (p + 1)) begin
        idle_ticks($urandom_range(0, 4));
        // about one sequence in four is broken: nack, timeout, stray requests
        broken = ($urandom_range(0, 3) == 0);
        nack = broken && ($urandom_range(0, 1) != 0);
        if (broken && lim <= 40 && $urandom_range(0, 1) != 0)
          highs = lim + 1 + $urandom_range(0, 3);
        else
          highs = $urandom_range(0, (lim < 6) ? lim : 6);
        plan_measurement(($urandom_range(0, 1) != 0) ? hstwm_pkg::OP_HUMIDITY
                                                     : hstwm_pkg::OP_TEMP,
                         nack, highs, read_pattern_t'($urandom_range(0, 2)), broken);
      end
    end
    idle_ticks(3);

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected result items never arrived", expected_results.size());
      fail_count++;
    end
    $display("checked %0d result items over %0d ticks", checked_count, queued_count);
    $display("%0d measurements completed, %0d of them with error flags and recovery pulses",
             done_count, flagged_done_count);
    if (fail_count == 0) begin
      $display("humidity_sensor_two_wire_master_top test passed");
    end else begin
      $display("humidity_sensor_two_wire_master_top test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #30_000_000;
    $display("humidity_sensor_two_wire_master_top test failed");
    $finish;
  end

endmodule

@@ files.f @@
src/hstwm_pkg.sv
src/hstwm_cfg.sv
src/hstwm_fsm.sv
src/humidity_sensor_two_wire_master_top.sv
src/hstwm_checker.sv
dv/humidity_sensor_two_wire_master_top_tb.sv
